FILE: design/rpn_stack_evaluator_assert.svh
// assertion macros for the rpn stack evaluator
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH
`ifndef SYNTH
`define RPN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rpn assertion failed");
`define RPN_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rpn assertion failed");
`else
`define RPN_ASSERT(lbl, clk, rst_n, prop)
`define RPN_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: design/rpn_pkg.sv
`default_nettype none
package rpn_pkg;
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [2:0] CMD_PUSH  = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_SUB   = 3'd2;
    localparam logic [2:0] CMD_MUL   = 3'd3;
    localparam logic [2:0] CMD_DIV   = 3'd4;
    localparam logic [2:0] CMD_MOD   = 3'd5;
    localparam logic [2:0] CMD_PRINT = 3'd6;

    localparam logic [63:0] SIGN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [63:0] operand;
    } t_in;

    typedef struct packed {
        logic               printed;
        logic signed [63:0] top_result;
        logic [1:0]         empty_pops;
        logic               stack_full;
        logic               zero_divisor;
        logic               saturated;
        logic [7:0]         depth;
    } t_out;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } t_alu_ctl;

    typedef struct packed {
        logic done;
        logic sat;
    } t_alu_sts;
endpackage
`default_nettype wire

FILE: design/rpn_stack_evaluator.sv
// rpn stack evaluator
// input channel: i_valid / o_stall with i_item (command, Q32.32 operand);
// an item is taken when i_valid is high and o_stall is low.
// output channel: o_valid / i_stall with o_item; one result item per input
// item, held in an output register until taken.
// the value stack is a single-port-write memory of STACK_DEPTH entries with
// a registered read; each pop goes through a pop state and then a get state.
// from accept: an unknown command goes straight to done, push writes the
// stack, print pops once, and add, subtract, multiply (four 32x32 partial
// products on one multiplier), modulus (32 divide steps) and divide (96 steps
// of the shared restoring divider, one quotient bit a cycle) pop two operands
// (one for a zero divisor), run the alu and push, then return to idle for
// the next item. o_stall stays high from accept until the result is loaded.
// the next item can be taken while the previous result still waits.
// when the receiver stalls with a result waiting, the finished item holds
// in its last state until the output register frees.
// reset clears the stack pointer, the sequencer and the output valid; stack
// memory contents are not cleared and need no clearing pass.
`default_nettype none
`include "rpn_stack_evaluator_assert.svh"
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_stall,
    input  rpn_pkg::t_in  i_item,
    output logic          o_valid,
    input  wire           i_stall,
    output rpn_pkg::t_out o_item
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POPB = 4'd1;
    localparam logic [3:0] S_GETB = 4'd2;
    localparam logic [3:0] S_POPA = 4'd3;
    localparam logic [3:0] S_GETA = 4'd4;
    localparam logic [3:0] S_ALU  = 4'd5;
    localparam logic [3:0] S_WAIT = 4'd6;
    localparam logic [3:0] S_PUSH = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]     r_state;
    logic [2:0]     r_cmd;
    logic [SPW-1:0] r_sp;
    logic [63:0]    r_a, r_b, r_pv, r_top, r_rdata;
    logic           r_hit, r_printed, r_full, r_zdiv, r_sat;
    logic [1:0]     r_empty;
    rpn_pkg::t_out  r_out;
    logic           r_ovalid;
    logic [63:0]    r_mem [STACK_DEPTH];

    logic [SPW-1:0] w_spm1;
    logic [AW-1:0]  w_ridx, w_widx;
    logic           w_we, w_accept, w_load;
    logic [63:0]    w_pop, w_magb;
    logic [SPW+7:0] w_dep;
    rpn_pkg::t_alu_ctl w_alu_ctl;
    rpn_pkg::t_alu_sts w_alu_sts;
    logic [63:0]    w_alu_res;

    assign w_spm1   = r_sp - SPW'(1);
    assign w_ridx   = w_spm1[AW-1:0];
    assign w_widx   = r_sp[AW-1:0];
    assign w_we     = (r_state == S_PUSH) && (r_sp < SPW'(STACK_DEPTH));
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || !i_stall);
    assign w_pop    = r_hit ? r_rdata : 64'd0;
    assign w_magb   = w_pop[63] ? (64'd0 - w_pop) : w_pop;
    assign w_dep    = {8'd0, r_sp};

    assign w_alu_ctl.start = (r_state == S_ALU);
    assign w_alu_ctl.op    = r_cmd;

    rpn_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_alu_ctl),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_sts    (w_alu_sts),
        .o_result (w_alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_widx] <= r_pv;
        end
        r_rdata <= r_mem[w_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.command == rpn_pkg::CMD_PUSH) begin
                            r_state <= S_PUSH;
                        end else if (i_item.command > rpn_pkg::CMD_PRINT) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_POPB;
                        end
                    end
                end
                S_POPB, S_POPA: begin
                    if (r_sp != '0) begin
                        r_sp <= w_spm1;
                    end
                    r_state <= (r_state == S_POPB) ? S_GETB : S_GETA;
                end
                S_GETB: begin
                    if (r_cmd == rpn_pkg::CMD_PRINT) begin
                        r_state <= S_DONE;
                    end else if (r_cmd == rpn_pkg::CMD_DIV && w_pop == 64'd0) begin
                        r_state <= S_DONE;
                    end else if (r_cmd == rpn_pkg::CMD_MOD &&
                                 w_magb[63:32] == 32'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_POPA;
                    end
                end
                S_GETA: r_state <= S_ALU;
                S_ALU:  r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_alu_sts.done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_we) begin
                        r_sp <= r_sp + SPW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd     <= i_item.command;
                r_pv      <= i_item.operand;
                r_top     <= 64'd0;
                r_printed <= 1'b0;
                r_full    <= 1'b0;
                r_zdiv    <= 1'b0;
                r_sat     <= 1'b0;
                r_empty   <= 2'd0;
            end
            S_POPB, S_POPA: begin
                r_hit <= (r_sp != '0);
                if (r_sp == '0) begin
                    r_empty <= r_empty + 2'd1;
                end
            end
            S_GETB: begin
                r_b <= w_pop;
                if (r_cmd == rpn_pkg::CMD_PRINT) begin
                    r_top     <= w_pop;
                    r_printed <= 1'b1;
                end else if (r_cmd == rpn_pkg::CMD_DIV && w_pop == 64'd0) begin
                    r_zdiv <= 1'b1;
                end else if (r_cmd == rpn_pkg::CMD_MOD &&
                             w_magb[63:32] == 32'd0) begin
                    r_zdiv <= 1'b1;
                end
            end
            S_GETA: r_a <= w_pop;
            S_WAIT: begin
                if (w_alu_sts.done) begin
                    r_pv  <= w_alu_res;
                    r_sat <= w_alu_sts.sat;
                end
            end
            S_PUSH: begin
                if (!w_we) begin
                    r_full <= 1'b1;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    r_out.printed      <= r_printed;
                    r_out.top_result   <= r_top;
                    r_out.empty_pops   <= r_empty;
                    r_out.stack_full   <= r_full;
                    r_out.zero_divisor <= r_zdiv;
                    r_out.saturated    <= r_sat;
                    r_out.depth        <= w_dep[7:0];
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    `RPN_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH))
    `RPN_ASSERT(a_accept_busy, i_clk, i_rst_n, w_accept |=> r_state != S_IDLE)
    `RPN_ASSERT(a_alu_done_wait, i_clk, i_rst_n, w_alu_sts.done |-> r_state == S_WAIT)
    `RPN_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> r_state == S_IDLE && !r_ovalid)
endmodule
`default_nettype wire

FILE: design/rpn_alu.sv
`default_nettype none
module rpn_alu (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rpn_pkg::t_alu_ctl   i_ctl,
    input  wire [63:0]          i_a,
    input  wire [63:0]          i_b,
    output rpn_pkg::t_alu_sts   o_sts,
    output logic [63:0]         o_result
);
    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_SIGN = 2'd3;

    logic [1:0]   r_st;
    logic [2:0]   r_op;
    logic [63:0]  r_a, r_b, r_ua, r_ub, r_d;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [6:0]   r_cnt;
    logic [63:0]  r_rem, r_q;
    logic [95:0]  r_num;
    logic         r_over;
    logic [63:0]  r_res;
    logic         r_sat, r_done;

    logic [63:0]  w_ua, w_ub;
    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_pp_sh;
    logic [64:0]  w_t, w_diff;
    logic         w_ge;
    logic [63:0]  w_mag, w_limit, w_sum, w_dif, w_rem;
    logic         w_ov, w_sat;
    logic [63:0]  w_res;

    assign w_ua = i_a[63] ? (64'd0 - i_a) : i_a;
    assign w_ub = i_b[63] ? (64'd0 - i_b) : i_b;

    // partial products of the magnitudes, one per cycle
    assign w_x  = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign w_y  = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
    assign w_pp = 64'(w_x) * 64'(w_y);
    always_comb begin
        w_pp_sh = {64'd0, w_pp};
        if (r_cnt[1] && r_cnt[0]) begin
            w_pp_sh = {w_pp, 64'd0};
        end else if (r_cnt[1] || r_cnt[0]) begin
            w_pp_sh = {32'd0, w_pp, 32'd0};
        end
    end

    // restoring divide step
    assign w_t    = {r_rem, r_num[95]};
    assign w_diff = w_t - {1'b0, r_d};
    assign w_ge   = (w_t >= {1'b0, r_d});

    assign w_sum = r_a + r_b;
    assign w_dif = r_a - r_b;
    assign w_rem = {r_rem[31:0], 32'd0};

    always_comb begin
        w_mag = r_q;
        w_ov  = r_over;
        if (r_op == rpn_pkg::CMD_MUL) begin
            w_mag = r_acc[95:32];
            w_ov  = |r_acc[127:96];
        end
        w_limit = r_neg ? rpn_pkg::SIGN_VAL : rpn_pkg::MAX_POS;
        w_sat   = 1'b0;
        w_res   = 64'd0;
        case (r_op)
            rpn_pkg::CMD_ADD: begin
                if (!(r_a[63] ^ r_b[63]) && (w_sum[63] ^ r_a[63])) begin
                    w_sat = 1'b1;
                    w_res = r_a[63] ? rpn_pkg::SIGN_VAL : rpn_pkg::MAX_POS;
                end else begin
                    w_res = w_sum;
                end
            end
            rpn_pkg::CMD_SUB: begin
                if ((r_a[63] ^ r_b[63]) && (w_dif[63] ^ r_a[63])) begin
                    w_sat = 1'b1;
                    w_res = r_a[63] ? rpn_pkg::SIGN_VAL : rpn_pkg::MAX_POS;
                end else begin
                    w_res = w_dif;
                end
            end
            rpn_pkg::CMD_MOD: begin
                w_res = r_a[63] ? (64'd0 - w_rem) : w_rem;
            end
            default: begin
                if (w_ov || (w_mag > w_limit)) begin
                    w_sat = 1'b1;
                    w_res = w_limit;
                end else begin
                    w_res = r_neg ? (64'd0 - w_mag) : w_mag;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= A_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                A_IDLE: begin
                    if (i_ctl.start) begin
                        if (i_ctl.op == rpn_pkg::CMD_MUL) begin
                            r_st <= A_MUL;
                        end else if (i_ctl.op == rpn_pkg::CMD_DIV ||
                                     i_ctl.op == rpn_pkg::CMD_MOD) begin
                            r_st <= A_DIV;
                        end else begin
                            r_st <= A_SIGN;
                        end
                    end
                end
                A_MUL: begin
                    if (r_cnt[1:0] == 2'd3) begin
                        r_st <= A_SIGN;
                    end
                end
                A_DIV: begin
                    if (r_cnt == 7'd0) begin
                        r_st <= A_SIGN;
                    end
                end
                A_SIGN: begin
                    r_done <= 1'b1;
                    r_st   <= A_IDLE;
                end
                default: r_st <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            A_IDLE: begin
                if (i_ctl.start) begin
                    r_op   <= i_ctl.op;
                    r_a    <= i_a;
                    r_b    <= i_b;
                    r_ua   <= w_ua;
                    r_ub   <= w_ub;
                    r_neg  <= i_a[63] ^ i_b[63];
                    r_acc  <= 128'd0;
                    r_rem  <= 64'd0;
                    r_q    <= 64'd0;
                    r_over <= 1'b0;
                    if (i_ctl.op == rpn_pkg::CMD_MOD) begin
                        r_num <= {w_ua[63:32], 64'd0};
                        r_d   <= {32'd0, w_ub[63:32]};
                        r_cnt <= 7'd31;
                    end else if (i_ctl.op == rpn_pkg::CMD_DIV) begin
                        r_num <= {w_ua, 32'd0};
                        r_d   <= w_ub;
                        r_cnt <= 7'd95;
                    end else begin
                        r_num <= 96'd0;
                        r_d   <= w_ub;
                        r_cnt <= 7'd0;
                    end
                end
            end
            A_MUL: begin
                r_acc <= r_acc + w_pp_sh;
                r_cnt <= r_cnt + 7'd1;
            end
            A_DIV: begin
                r_rem  <= w_ge ? w_diff[63:0] : w_t[63:0];
                r_over <= r_over | r_q[63];
                r_q    <= {r_q[62:0], w_ge};
                r_num  <= {r_num[94:0], 1'b0};
                r_cnt  <= r_cnt - 7'd1;
            end
            A_SIGN: begin
                r_res <= w_res;
                r_sat <= w_sat;
            end
            default: ;
        endcase
    end

    assign o_sts.done = r_done;
    assign o_sts.sat  = r_sat;
    assign o_result   = r_res;
endmodule
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1562;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] CMD_BAD = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in i_item = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_item;

    always #5 i_clk = ~i_clk;

    rpn_stack_evaluator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    // predictor state
    logic [63:0] calc_stack [DEPTH];
    int          calc_sp;
    int          calc_empty;
    logic        calc_full;
    logic        calc_sat;
    t_out        pending_results [$];

    int   fail_count = 0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    function automatic void calc_push(input logic [63:0] v);
        if (calc_sp < DEPTH) begin
            calc_stack[calc_sp] = v;
            calc_sp++;
        end else begin
            calc_full = 1'b1;
        end
    endfunction

    function automatic logic [63:0] calc_pop();
        if (calc_sp > 0) begin
            calc_sp--;
            return calc_stack[calc_sp];
        end
        calc_empty++;
        return '0;
    endfunction

    function automatic logic [63:0] clamp(input logic [64:0] mag, input logic neg);
        if (neg ? (mag > {1'b0, SIGN_VAL}) : (mag > {1'b0, MAX_POS})) begin
            calc_sat = 1'b1;
            return neg ? SIGN_VAL : MAX_POS;
        end
        return neg ? 64'(-mag[63:0]) : mag[63:0];
    endfunction

    function automatic t_out calc_item(input t_in it);
        t_out r;
        logic signed [63:0] a, b;
        logic signed [64:0] s;
        logic [63:0] ma, mb;
        logic [127:0] prod, q;
        r = '0;
        calc_empty = 0;
        calc_full = 1'b0;
        calc_sat = 1'b0;
        case (it.command)
            CMD_PUSH: calc_push(it.operand);
            CMD_ADD, CMD_SUB: begin
                b = calc_pop();
                a = calc_pop();
                s = (it.command == CMD_ADD) ? (65'(a) + 65'(b)) : (65'(a) - 65'(b));
                if (s > 65'sd9223372036854775807) begin
                    calc_sat = 1'b1;
                    calc_push(MAX_POS);
                end else if (s < -65'sd9223372036854775808) begin
                    calc_sat = 1'b1;
                    calc_push(SIGN_VAL);
                end else begin
                    calc_push(s[63:0]);
                end
            end
            CMD_MUL: begin
                b = calc_pop();
                a = calc_pop();
                ma = a[63] ? -a : a;
                mb = b[63] ? -b : b;
                prod = {64'd0, ma} * {64'd0, mb};
                if (prod[127:96] != 0) begin
                    calc_sat = 1'b1;
                    calc_push((a[63] ^ b[63]) ? SIGN_VAL : MAX_POS);
                end else begin
                    calc_push(clamp({1'b0, prod[95:32]}, a[63] ^ b[63]));
                end
            end
            CMD_DIV: begin
                b = calc_pop();
                if (b == 0) begin
                    r.zero_divisor = 1'b1;
                end else begin
                    a = calc_pop();
                    ma = a[63] ? -a : a;
                    mb = b[63] ? -b : b;
                    q = {ma, 32'd0} / {64'd0, mb};
                    if (q[127:64] != 0) begin
                        calc_sat = 1'b1;
                        calc_push((a[63] ^ b[63]) ? SIGN_VAL : MAX_POS);
                    end else begin
                        calc_push(clamp({1'b0, q[63:0]}, a[63] ^ b[63]));
                    end
                end
            end
            CMD_MOD: begin
                b = calc_pop();
                mb = (b[63] ? -b : b) >> 32;
                if (mb == 0) begin
                    r.zero_divisor = 1'b1;
                end else begin
                    a = calc_pop();
                    ma = (a[63] ? -a : a) >> 32;
                    ma = (ma % mb) << 32;
                    calc_push(a[63] ? -ma : ma);
                end
            end
            CMD_PRINT: begin
                r.top_result = calc_pop();
                r.printed = 1'b1;
            end
            default: ;
        endcase
        r.empty_pops = 2'(calc_empty);
        r.stack_full = calc_full;
        r.saturated = calc_sat;
        r.depth = 8'(calc_sp);
        return r;
    endfunction

    // result checking
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", o_item.top_result, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_item.printed !== want.printed)
                    report_mismatch("printed", o_item.printed, want.printed);
                if (o_item.top_result !== want.top_result)
                    report_mismatch("top_result", o_item.top_result, want.top_result);
                if (o_item.empty_pops !== want.empty_pops)
                    report_mismatch("empty_pops", o_item.empty_pops, want.empty_pops);
                if (o_item.stack_full !== want.stack_full)
                    report_mismatch("stack_full", o_item.stack_full, want.stack_full);
                if (o_item.zero_divisor !== want.zero_divisor)
                    report_mismatch("zero_divisor", o_item.zero_divisor, want.zero_divisor);
                if (o_item.saturated !== want.saturated)
                    report_mismatch("saturated", o_item.saturated, want.saturated);
                if (o_item.depth !== want.depth)
                    report_mismatch("depth", o_item.depth, want.depth);
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // send one item, updating the predictor on acceptance
    task automatic send_item(input t_in it, input bit typed, input t_out typed_want);
        t_out want;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = calc_item(it);
        if (typed && want !== typed_want)
            report_mismatch("typed expectation", want.depth, typed_want.depth);
        pending_results.push_back(want);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    function automatic t_out out_of(input logic p, input logic [63:0] top,
                                    input logic [1:0] ep, input logic zd,
                                    input logic sat, input logic [7:0] d);
        t_out r;
        r = '0;
        r.printed = p;
        r.top_result = top;
        r.empty_pops = ep;
        r.zero_divisor = zd;
        r.saturated = sat;
        r.depth = d;
        return r;
    endfunction

    function automatic logic [63:0] random_value();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return {{32{$urandom_range(1)}}, $urandom} << 32;
            2: return 64'($signed($urandom_range(40)) - 20) << 32;
            3: return $urandom_range(1) ? SIGN_VAL : MAX_POS;
            4: return 64'($signed($urandom_range(6)) - 3);
            default: return {{24{1'b0}}, $urandom_range(255), $urandom};
        endcase
    endfunction

    typedef struct {
        t_in  it;
        bit   typed;
        t_out want;
    } t_row;

    t_row directed_rows [$];

    task automatic add_row(input logic [2:0] c, input logic [63:0] v,
                           input bit typed, input t_out w);
        t_row row;
        row.it.command = c;
        row.it.operand = v;
        row.typed = typed;
        row.want = w;
        directed_rows.push_back(row);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in it;
        int phase;
        calc_sp = 0;
        add_row(CMD_PRINT, '0, 1, out_of(1, '0, 2'd1, 0, 0, 8'd0));
        add_row(CMD_ADD, '0, 1, out_of(0, '0, 2'd2, 0, 0, 8'd1));
        add_row(CMD_DIV, '0, 1, out_of(0, '0, 2'd0, 1, 0, 8'd0));
        add_row(CMD_PUSH, MAX_POS, 1, out_of(0, '0, 2'd0, 0, 0, 8'd1));
        add_row(CMD_PUSH, 64'd1, 0, '0);
        add_row(CMD_ADD, '0, 1, out_of(0, '0, 2'd0, 0, 1, 8'd1));
        add_row(CMD_PUSH, SIGN_VAL, 0, '0);
        add_row(CMD_SUB, '0, 0, '0);
        add_row(CMD_PUSH, SIGN_VAL, 0, '0);
        add_row(CMD_PUSH, 64'hFFFF_FFFF_0000_0000, 0, '0);
        add_row(CMD_MUL, '0, 0, '0);
        add_row(CMD_PUSH, 64'h0000_0003_0000_0000, 0, '0);
        add_row(CMD_PUSH, 64'h0000_0000_8000_0000, 0, '0);
        add_row(CMD_DIV, '0, 0, '0);
        add_row(CMD_PUSH, 64'hFFFF_FFF9_0000_0000, 0, '0);
        add_row(CMD_PUSH, 64'h0000_0002_8000_0000, 0, '0);
        add_row(CMD_MOD, '0, 0, '0);
        add_row(CMD_PUSH, 64'h0000_0000_7FFF_FFFF, 0, '0);
        add_row(CMD_MOD, '0, 0, '0);
        add_row(CMD_PUSH, 64'hFFFF_FFFF_8000_0000, 0, '0);
        add_row(CMD_PUSH, 64'hFFFF_FFFF_0000_0000, 0, '0);
        add_row(CMD_MOD, '0, 0, '0);
        add_row(CMD_PRINT, '0, 0, '0);
        add_row(CMD_BAD, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0);
        add_row(CMD_PRINT, '0, 0, '0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k])
            send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want);

        // fill past full while the receiver holds off
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < DEPTH + 4; k++) begin
                it.command = CMD_PUSH;
                it.operand = random_value();
                send_item(it, 0, '0);
            end
        join
        for (int k = 0; k < DEPTH + 3; k++) begin
            it.command = CMD_PRINT;
            it.operand = random_value();
            send_item(it, 0, '0);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n * 4) / RANDOM_ITEMS;
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 32 : 62) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 32 : 62) : 0;
            if (calc_sp < 2 || $urandom_range(99) < 45)
                it.command = CMD_PUSH;
            else if ($urandom_range(99) < 3)
                it.command = CMD_BAD;
            else
                it.command = 3'($urandom_range(CMD_PRINT, CMD_ADD));
            it.operand = random_value();
            send_item(it, 0, '0);
        end
        recv_stall_pct = 0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: rpn_stack_evaluator.f
+incdir+design
design/rpn_pkg.sv
design/rpn_alu.sv
design/rpn_stack_evaluator.sv
test/testbench.sv
